### sv/ilut_pkg.sv
// ----------------------------------------------------------------------------
// ilut_pkg
// Shared constants, types and helpers for the inverse piecewise-linear lookup.
// ----------------------------------------------------------------------------
package ilut_pkg;

    localparam int MAX_KNOTS   = 64;
    localparam int IDX_W       = $clog2(MAX_KNOTS);
    localparam int CNT_W       = $clog2(MAX_KNOTS + 1);

    localparam int KEY_W       = 7;
    localparam int TIME_W      = 32;
    localparam int TRAVEL_W    = 31;
    localparam int DIST_W      = 32;
    localparam int ENTRY_IDX_W = 6;
    localparam int KNOT_W      = TIME_W + TRAVEL_W;
    localparam int PROD_W      = TIME_W + TRAVEL_W;
    localparam int TRAVEL_EPS  = 7;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 32;
    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_COUNT     = 2'd0,
        CFG_TOTAL_TRAVEL  = 2'd1,
        CFG_CLIP_DURATION = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_QUERY = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_SEG,
        ST_MUL,
        ST_DIVS,
        ST_DIVW,
        ST_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Slot number of a write request mapped onto the table address.
    function automatic logic [IDX_W-1:0] to_addr(input logic [ENTRY_IDX_W-1:0] idx);
        logic [ENTRY_IDX_W+IDX_W-1:0] wide;
        wide = {IDX_W'(0), idx};
        return wide[IDX_W-1:0];
    endfunction

    function automatic logic slot_ok(input logic [ENTRY_IDX_W-1:0] idx);
        logic [ENTRY_IDX_W+IDX_W-1:0] wide;
        wide = {IDX_W'(0), idx};
        return (int'(wide) < MAX_KNOTS);
    endfunction

endpackage

### sv/ilut_ram.sv
// ----------------------------------------------------------------------------
// ilut_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ilut_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ilut_div.sv
// ----------------------------------------------------------------------------
// ilut_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ilut_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ilut_pkg::PROD_W-1:0]     i_dividend,
    input  logic [ilut_pkg::TRAVEL_W-1:0]   i_divisor,
    output ilut_pkg::t_div_stat             o_stat,
    output logic [ilut_pkg::PROD_W-1:0]     o_quot
);

    localparam int STEP_W = $clog2(ilut_pkg::PROD_W);

    logic [ilut_pkg::PROD_W-1:0]   r_n;
    logic [ilut_pkg::TRAVEL_W-1:0] r_rem;
    logic [ilut_pkg::TRAVEL_W-1:0] r_den;
    logic [STEP_W-1:0]             r_step;
    logic                          r_busy;
    logic                          r_done;

    logic [ilut_pkg::TRAVEL_W:0]   w_trial;
    logic [ilut_pkg::TRAVEL_W+1:0] w_diff;
    logic                          w_qbit;

    assign w_trial = {r_rem, r_n[ilut_pkg::PROD_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};
    assign w_qbit  = ~w_diff[ilut_pkg::TRAVEL_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(ilut_pkg::PROD_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_n   <= {r_n[ilut_pkg::PROD_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[ilut_pkg::TRAVEL_W-1:0] : w_trial[ilut_pkg::TRAVEL_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_n;

endmodule

### sv/inverse_piecewise_linear_lookup.sv
// ----------------------------------------------------------------------------
// inverse_piecewise_linear_lookup
// Knot table of (time, travel) pairs; a query returns the time at which a
// given travel is reached, interpolated linearly between knots.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                Payload
// --------  ---  -----------------------  ---------------------------------------
// s_axis    in   s_axis_tvalid/tready     tuser: operation; tdata: knot or query
// m_axis    out  m_axis_tvalid/tready     tdata: travel_time
// cfg       in   i_cfg_we (no wait)       i_cfg_idx, i_cfg_data
//
// Flow: a knot write is taken in the idle state. A query settled by the range checks
// goes straight to the result hand-off; an interpolated one walks the table (one RAM
// read per slot), then forms the segment, multiplies, divides (63 quotient bits) and adds t0.
// Reset: synchronous, active low; clears configuration and control, not the datapath or the table.
// Stalls: one request at a time is worked on; the output register lets the
// next request in while a result waits for m_axis_tready.
//
module inverse_piecewise_linear_lookup (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [5:0] entry_index, [37:6] entry_time, [68:38] entry_travel,
    // [100:69] distance, [103:101] zero
    input  logic [ilut_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] operation
    input  logic [0:0]                        s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] travel_time
    output logic [ilut_pkg::OUT_DATA_W-1:0]   m_axis_tdata,

    input  logic                              i_cfg_we,
    input  logic [ilut_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ilut_pkg::CFG_W-1:0]        i_cfg_data
);

    // ---------------- request fields ----------------
    ilut_pkg::t_op                          w_op;
    logic [ilut_pkg::ENTRY_IDX_W-1:0]       w_eidx;
    logic [ilut_pkg::TIME_W-1:0]            w_etime;
    logic [ilut_pkg::TRAVEL_W-1:0]          w_etrav;
    logic signed [ilut_pkg::DIST_W-1:0]     w_dist;

    assign w_op    = ilut_pkg::t_op'(s_axis_tuser[0]);
    assign w_eidx  = s_axis_tdata[5:0];
    assign w_etime = s_axis_tdata[37:6];
    assign w_etrav = s_axis_tdata[68:38];
    assign w_dist  = $signed(s_axis_tdata[100:69]);

    // ---------------- configuration registers ----------------
    logic [ilut_pkg::KEY_W-1:0]    r_key_count;
    logic [ilut_pkg::TRAVEL_W-1:0] r_total;
    logic [ilut_pkg::TIME_W-1:0]   r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_total     <= '0;
            r_clip      <= '0;
        end else if (i_cfg_we) begin
            case (ilut_pkg::t_cfg_idx'(i_cfg_idx))
                ilut_pkg::CFG_KEY_COUNT:     r_key_count <= i_cfg_data[ilut_pkg::KEY_W-1:0];
                ilut_pkg::CFG_TOTAL_TRAVEL:  r_total     <= i_cfg_data[ilut_pkg::TRAVEL_W-1:0];
                ilut_pkg::CFG_CLIP_DURATION: r_clip      <= i_cfg_data[ilut_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Knot count, clamped to the table depth.
    logic [ilut_pkg::CNT_W-1:0] w_cnt;
    always_comb begin
        if (int'(r_key_count) > ilut_pkg::MAX_KNOTS) begin
            w_cnt = ilut_pkg::CNT_W'(ilut_pkg::MAX_KNOTS);
        end else begin
            w_cnt = ilut_pkg::CNT_W'(r_key_count);
        end
    end

    // ---------------- state ----------------
    ilut_pkg::t_state r_state, n_state;

    logic [ilut_pkg::IDX_W-1:0]    r_addr;     // next read address of the walk
    logic [ilut_pkg::IDX_W-1:0]    r_rd_idx;   // slot whose data is on the RAM output
    logic                          r_rd_vld;
    logic [ilut_pkg::TRAVEL_W-1:0] r_dist;     // query distance, known positive here
    logic [ilut_pkg::TIME_W-1:0]   r_t0, r_t1;
    logic [ilut_pkg::TRAVEL_W-1:0] r_v0, r_v1;
    logic [ilut_pkg::TRAVEL_W-1:0] r_segd;
    logic [ilut_pkg::TIME_W-1:0]   r_dtm;      // |t1 - t0|
    logic [ilut_pkg::TRAVEL_W-1:0] r_ndm;      // |dist - v0|
    logic                          r_neg;
    logic [ilut_pkg::PROD_W-1:0]   r_prod;
    logic [ilut_pkg::TIME_W-1:0]   r_res, n_res;
    logic                          r_o_valid;
    logic [ilut_pkg::TIME_W-1:0]   r_o_data;

    // ---------------- knot table ----------------
    logic                          w_ram_we;
    logic [ilut_pkg::IDX_W-1:0]    w_ram_raddr;
    logic [ilut_pkg::KNOT_W-1:0]   w_ram_rdata;
    logic [ilut_pkg::TIME_W-1:0]   w_rd_time;
    logic [ilut_pkg::TRAVEL_W-1:0] w_rd_trav;

    assign w_ram_raddr = r_addr;
    assign w_rd_time   = w_ram_rdata[ilut_pkg::KNOT_W-1:ilut_pkg::TRAVEL_W];
    assign w_rd_trav   = w_ram_rdata[ilut_pkg::TRAVEL_W-1:0];

    ilut_ram #(
        .WIDTH (ilut_pkg::KNOT_W),
        .DEPTH (ilut_pkg::MAX_KNOTS)
    ) u_knots (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (ilut_pkg::to_addr(w_eidx)),
        .i_wdata ({w_etime, w_etrav}),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // ---------------- divider ----------------
    logic                 w_div_start;
    ilut_pkg::t_div_stat  w_div_stat;
    logic [ilut_pkg::PROD_W-1:0] w_quot;

    ilut_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_segd),
        .o_stat     (w_div_stat),
        .o_quot     (w_quot)
    );

    // ---------------- datapath helpers ----------------
    logic w_accept, w_dist_le0, w_to_clip, w_hit, w_last, w_out_load;
    assign w_accept   = s_axis_tvalid & s_axis_tready;
    assign w_dist_le0 = w_dist[ilut_pkg::DIST_W-1] | (w_dist == '0);
    // Clip end: at or past total travel, a degenerate total, or a single knot.
    assign w_to_clip  = (w_dist[ilut_pkg::TRAVEL_W-1:0] >= r_total)
                      | (r_total <= ilut_pkg::TRAVEL_W'(ilut_pkg::TRAVEL_EPS))
                      | (w_cnt == ilut_pkg::CNT_W'(1));
    assign w_hit      = (w_rd_trav >= r_dist);
    assign w_last     = (ilut_pkg::CNT_W'(r_rd_idx) == (w_cnt - 1'b1));

    // Segment length and signed differences for interpolation.
    logic signed [ilut_pkg::TRAVEL_W:0] w_seg;   // v1 - v0
    logic signed [ilut_pkg::TIME_W:0]   w_dt;    // t1 - t0
    logic signed [ilut_pkg::TRAVEL_W:0] w_nd;    // dist - v0
    logic                               w_flat;
    logic [ilut_pkg::TIME_W:0]          w_dt_abs;
    logic [ilut_pkg::TRAVEL_W:0]        w_nd_abs;

    assign w_seg    = $signed({1'b0, r_v1}) - $signed({1'b0, r_v0});
    assign w_dt     = $signed({1'b0, r_t1}) - $signed({1'b0, r_t0});
    assign w_nd     = $signed({1'b0, r_dist}) - $signed({1'b0, r_v0});
    assign w_flat   = (w_seg <= $signed((ilut_pkg::TRAVEL_W+1)'(ilut_pkg::TRAVEL_EPS)));
    assign w_dt_abs = w_dt[ilut_pkg::TIME_W] ? 33'(-w_dt) : 33'(w_dt);
    assign w_nd_abs = w_nd[ilut_pkg::TRAVEL_W] ? 32'(-w_nd) : 32'(w_nd);

    // Final add of the signed quotient to t0, saturated to 32 bits.
    logic [ilut_pkg::PROD_W:0] w_sum;
    logic [ilut_pkg::TIME_W-1:0] w_sat;
    assign w_sum = {(ilut_pkg::PROD_W+1-ilut_pkg::TIME_W)'(0), r_t0} + {1'b0, w_quot};
    always_comb begin
        if (r_neg) begin
            if (w_quot > ilut_pkg::PROD_W'(r_t0)) begin
                w_sat = '0;
            end else begin
                w_sat = r_t0 - w_quot[ilut_pkg::TIME_W-1:0];
            end
        end else if (w_sum[ilut_pkg::PROD_W:ilut_pkg::TIME_W] != '0) begin
            w_sat = '1;
        end else begin
            w_sat = w_sum[ilut_pkg::TIME_W-1:0];
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ilut_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_res         = r_res;
        s_axis_tready = 1'b0;
        w_ram_we      = 1'b0;
        w_div_start   = 1'b0;
        w_out_load    = 1'b0;
        case (r_state)
            ilut_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (w_op == ilut_pkg::OP_WRITE) begin
                        w_ram_we = ilut_pkg::slot_ok(w_eidx);
                    end else if (w_dist_le0 || (w_cnt == '0)) begin
                        n_res   = '0;
                        n_state = ilut_pkg::ST_DONE;
                    end else if (w_to_clip) begin
                        n_res   = r_clip;
                        n_state = ilut_pkg::ST_DONE;
                    end else begin
                        n_state = ilut_pkg::ST_WALK;
                    end
                end
            end
            ilut_pkg::ST_WALK: begin
                if (r_rd_vld && (r_rd_idx != '0)) begin
                    if (w_hit) begin
                        n_state = ilut_pkg::ST_SEG;
                    end else if (w_last) begin
                        n_res   = r_clip;
                        n_state = ilut_pkg::ST_DONE;
                    end
                end
            end
            ilut_pkg::ST_SEG: begin
                if (w_flat) begin
                    n_res   = r_t1;
                    n_state = ilut_pkg::ST_DONE;
                end else begin
                    n_state = ilut_pkg::ST_MUL;
                end
            end
            ilut_pkg::ST_MUL: begin
                n_state = ilut_pkg::ST_DIVS;
            end
            ilut_pkg::ST_DIVS: begin
                w_div_start = 1'b1;
                n_state     = ilut_pkg::ST_DIVW;
            end
            ilut_pkg::ST_DIVW: begin
                if (w_div_stat.done) begin
                    n_state = ilut_pkg::ST_FIN;
                end
            end
            ilut_pkg::ST_FIN: begin
                n_res   = w_sat;
                n_state = ilut_pkg::ST_DONE;
            end
            ilut_pkg::ST_DONE: begin
                if (!r_o_valid || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = ilut_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ilut_pkg::ST_IDLE;
            end
        endcase
    end

    // Walk bookkeeping: reads stream one slot per cycle, each slot's data following in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
        end else if (r_state == ilut_pkg::ST_WALK) begin
            r_addr   <= r_addr + 1'b1;
            r_rd_vld <= 1'b1;
        end else begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_rd_idx <= r_addr;
        if (w_accept) begin
            r_dist <= w_dist[ilut_pkg::TRAVEL_W-1:0];
        end
        if ((r_state == ilut_pkg::ST_WALK) && r_rd_vld) begin
            if (w_hit && (r_rd_idx != '0)) begin
                r_t1 <= w_rd_time;
                r_v1 <= w_rd_trav;
            end else begin
                r_t0 <= w_rd_time;
                r_v0 <= w_rd_trav;
            end
        end
        if (r_state == ilut_pkg::ST_SEG) begin
            r_segd <= w_seg[ilut_pkg::TRAVEL_W-1:0];
            r_dtm  <= w_dt_abs[ilut_pkg::TIME_W-1:0];
            r_ndm  <= w_nd_abs[ilut_pkg::TRAVEL_W-1:0];
            r_neg  <= w_dt[ilut_pkg::TIME_W] ^ w_nd[ilut_pkg::TRAVEL_W];
        end
        if (r_state == ilut_pkg::ST_MUL) begin
            r_prod <= ilut_pkg::PROD_W'(r_dtm) * ilut_pkg::PROD_W'(r_ndm);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_data <= r_res;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

    // ---------------- assertions ----------------
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_div_stat.busy)
        else $error("request taken while divider busy");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ilut_pkg::ST_DONE))
        else $error("result raised outside result hand-off");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == ilut_pkg::ST_DIVW))
        else $error("divider finished outside its wait state");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ilut_pkg::ST_WALK) && r_rd_vld) |-> (ilut_pkg::CNT_W'(r_rd_idx) < w_cnt))
        else $error("table walk ran past the knot count");

endmodule
